// File: hw/rtl/fet_pkg.sv
package fet_pkg;

	// Default number of fraction bits of the fixed-point coordinates.
	localparam int FRAC_BITS_DEF = 28;
	// Default number of palette entries that the iteration count cycles through.
	localparam int COLOR_COUNT_DEF = 15;

	localparam int COORD_W = 32;
	localparam int RADIUS_W = 36;
	localparam int ITER_W = 16;
	localparam int COLOR_W = 4;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 36;

	// Register values after reset.
	localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET = 36'h1_0000_0000;
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd75;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VARIANT      = 3'd0,
		REG_JULIA_C_REAL = 3'd1,
		REG_JULIA_C_IMAG = 3'd2,
		REG_RADIUS_SQ    = 3'd3,
		REG_MAX_ITER     = 3'd4
	} cfg_reg_t;

	// Set selection held in the variant register.
	localparam logic VARIANT_MANDELBROT = 1'b0;
	localparam logic VARIANT_JULIA = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_real;
		logic signed [COORD_W-1:0] point_imag;
	} in_word_t;

	typedef struct packed {
		logic [ITER_W-1:0] iterations;
		logic [COLOR_W-1:0] color_index;
	} out_word_t;

endpackage

// File: hw/rtl/fractal_escape_time.sv
// Escape-time evaluator for the Mandelbrot and Julia sets in signed fixed point.
// Input channel (in_valid, in_stall, in_word): one word carries one complex point.
// A word is taken at a clock edge with in_valid high and in_stall low. The block
// works on one point at a time and holds in_stall high from the accepting edge
// until the result has been moved into the output register.
// Output channel (out_valid, out_stall, out_word): one word per point with the
// iteration count and a palette index. An output register separates the two
// sides, so a new point is accepted while the previous result still waits.
// Each iteration of z = z*z + c goes through one shared 32x32 multiplier for
// zr*zr, zi*zi and zr*zi in turn, followed by the escape test and the update.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while the block is idle, and the block itself does not enforce
// this. Reset selects Mandelbrot mode, a squared radius of 2^32 (16.0 with 28
// fraction bits), a limit of 75 and a Julia constant of zero, and drops any
// pending result. When the receiver stalls, the result stays in the output
// register and the block stops after its next point until the register frees.
module fractal_escape_time #(
	parameter int FRAC_BITS = fet_pkg::FRAC_BITS_DEF,
	parameter int COLOR_COUNT = fet_pkg::COLOR_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  fet_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output fet_pkg::out_word_t out_word,
	input  logic cfg_write,
	input  logic [fet_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fet_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLOR_COUNT - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL_RR = 6'b000010,
		ST_MUL_II = 6'b000100,
		ST_MUL_RI = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic variant_q;
	logic signed [31:0] julia_cr_q;
	logic signed [31:0] julia_ci_q;
	logic [fet_pkg::RADIUS_W-1:0] radius_sq_q;
	logic [fet_pkg::ITER_W-1:0] max_iter_q;

	// Iteration state.
	logic signed [31:0] zr_q;
	logic signed [31:0] zi_q;
	logic signed [31:0] cr_q;
	logic signed [31:0] ci_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] rr_q;
	logic signed [63:0] ii_q;
	logic [fet_pkg::ITER_W-1:0] n_q;
	logic [COL_W-1:0] col_q;
	logic limit_q;

	logic out_valid_q;
	fet_pkg::out_word_t out_word_q;

	logic in_accept;
	logic out_free;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic [63:0] sum_sq;
	logic [63:0] mag;
	logic escape;
	logic signed [63:0] diff;
	logic signed [63:0] re_full;
	logic signed [63:0] im_full;
	logic [fet_pkg::ITER_W-1:0] n_next;
	logic [8:0] color_sum;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = (state_q == ST_MUL_II) ? zi_q : zr_q;
		mul_b = (state_q == ST_MUL_RR) ? zr_q : zi_q;
		mul_p = mul_a * mul_b;
	end

	// Escape test and next z from the three registered products.
	always_comb begin
		sum_sq = $unsigned(rr_q) + $unsigned(ii_q);
		mag = sum_sq >> FRAC_BITS;
		escape = mag > {{(64 - fet_pkg::RADIUS_W){1'b0}}, radius_sq_q};
		diff = rr_q - ii_q;
		// The sign extension of c stays signed so that the shifts round toward minus infinity.
		re_full = (diff >>> FRAC_BITS) + $signed({{32{cr_q[31]}}, cr_q});
		im_full = (prod_q >>> (FRAC_BITS - 1)) + $signed({{32{ci_q[31]}}, ci_q});
		n_next = n_q + 16'd1;
		color_sum = 9'(col_q) + 9'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= fet_pkg::VARIANT_MANDELBROT;
			julia_cr_q <= '0;
			julia_ci_q <= '0;
			radius_sq_q <= fet_pkg::RADIUS_SQ_RESET;
			max_iter_q <= fet_pkg::MAX_ITER_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				fet_pkg::REG_VARIANT: variant_q <= cfg_data[0];
				fet_pkg::REG_JULIA_C_REAL: julia_cr_q <= cfg_data[31:0];
				fet_pkg::REG_JULIA_C_IMAG: julia_ci_q <= cfg_data[31:0];
				fet_pkg::REG_RADIUS_SQ: radius_sq_q <= cfg_data[fet_pkg::RADIUS_W-1:0];
				fet_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[fet_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			col_q <= '0;
			limit_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						n_q <= '0;
						col_q <= '0;
						if (max_iter_q == '0) begin
							limit_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							limit_q <= 1'b0;
							state_q <= ST_MUL_RR;
						end
					end
				end
				ST_MUL_RR: state_q <= ST_MUL_II;
				ST_MUL_II: state_q <= ST_MUL_RI;
				ST_MUL_RI: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (escape) begin
						state_q <= ST_DONE;
					end else begin
						n_q <= n_next;
						col_q <= (col_q == COL_LAST) ? '0 : col_q + 1'b1;
						if (n_next >= max_iter_q) begin
							limit_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL_RR;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers hold no control meaning and need no reset.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (variant_q == fet_pkg::VARIANT_JULIA) begin
				zr_q <= in_word.point_real;
				zi_q <= in_word.point_imag;
				cr_q <= julia_cr_q;
				ci_q <= julia_ci_q;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= in_word.point_real;
				ci_q <= in_word.point_imag;
			end
		end else if (state_q == ST_UPDATE && !escape) begin
			zr_q <= sat32(re_full);
			zi_q <= sat32(im_full);
		end
		if (state_q == ST_MUL_RR || state_q == ST_MUL_II || state_q == ST_MUL_RI) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MUL_II) begin
			rr_q <= prod_q;
		end
		if (state_q == ST_MUL_RI) begin
			ii_q <= prod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_word_q.iterations <= n_q;
			out_word_q.color_index <= limit_q ? '0 : color_sum[fet_pkg::COLOR_W-1:0];
		end
	end

	// An accepted point always starts an iteration or ends at once on a zero limit.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_MUL_RR || state_q == ST_DONE))
		else $error("accepted point did not start iterating");

	// The palette counter stays below the palette size.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST)
		else $error("palette counter out of range");

	// A new result only appears after the sequencer has finished a point.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished point");

	// The sequencer leaves the done state only when the output register takes the result.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output register was full");

endmodule
